@@ hw/rtl/mst_pkg.sv @@
// Shared widths, field offsets, codes and limits of the shake telemetry block.
package mst_pkg;

   // Sample width and everything derived from it.
   localparam int ACCEL_WIDTH    = 16;
   localparam int SQ_WIDTH       = 2 * ACCEL_WIDTH;
   localparam int BASE_WIDTH     = ACCEL_WIDTH + 1;
   localparam int DIFF_WIDTH     = BASE_WIDTH + 2;
   localparam int SER_CNT_WIDTH  = $clog2(ACCEL_WIDTH);

   // Fixed field widths.
   localparam int THR_WIDTH      = 15;
   localparam int WGT_WIDTH      = 16;
   localparam int PER_WIDTH      = 16;
   localparam int TIME_WIDTH     = 32;
   localparam int DIV_CNT_WIDTH  = $clog2(TIME_WIDTH);
   localparam int UPTIME_WIDTH   = 23;
   localparam int TILT_WIDTH     = 14;
   localparam int CODE_WIDTH     = 3;
   localparam int GEST_WIDTH     = 3;
   localparam int PERSONA_WIDTH  = 4;
   localparam int COUNT_WIDTH    = 32;
   localparam int PROD_WIDTH     = DIFF_WIDTH + WGT_WIDTH + 1;

   // Divider for uptime seconds.
   localparam int MS_PER_SECOND  = 1000;
   localparam int DIV_REM_WIDTH  = 10;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SHAKE_THRESHOLD = 2'd0,
      CSR_EMA_WEIGHT      = 2'd1,
      CSR_TELEMETRY_PERIOD = 2'd2
   } csr_index_type;

   localparam logic [THR_WIDTH-1:0] THR_RESET    = 15'd3277;
   localparam logic [WGT_WIDTH-1:0] WGT_RESET    = 16'd3277;
   localparam logic [PER_WIDTH-1:0] PER_RESET    = 16'd100;

   // Behavior constants, all in Q4.12 g where they are accelerations.
   localparam int ONE_G          = 4096;
   localparam int FACEDOWN_LIMIT = -2867;
   localparam int WAVE_LIMIT     = 2252;
   localparam int LEAN_LIMIT     = 2048;
   localparam int PERSONA_COUNT  = 7;
   localparam logic [PERSONA_WIDTH-1:0] PERSONA_NONE = 4'd15;
   localparam logic [CODE_WIDTH-1:0]    PERSONA_IDLE = 3'd1;

   typedef enum logic [GEST_WIDTH-1:0] {
      GEST_IDLE       = 3'd0,
      GEST_DIZZY      = 3'd1,
      GEST_FACEDOWN   = 3'd2,
      GEST_WAVE       = 3'd3,
      GEST_LEAN_RIGHT = 3'd4,
      GEST_LEAN_LEFT  = 3'd5
   } gesture_type;

   typedef enum logic {
      KIND_STATE     = 1'b0,
      KIND_TELEMETRY = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_MULT,
      ST_UPDATE,
      ST_EVENT,
      ST_RECORD
   } state_type;

   // Request word layout, lowest bit first.
   localparam int REQ_AX_LO      = 0;
   localparam int REQ_AY_LO      = ACCEL_WIDTH;
   localparam int REQ_AZ_LO      = 2 * ACCEL_WIDTH;
   localparam int REQ_PERSONA_LO = 3 * ACCEL_WIDTH;
   localparam int REQ_SHAKE_BIT  = REQ_PERSONA_LO + PERSONA_WIDTH;
   localparam int REQ_TIME_LO    = REQ_SHAKE_BIT + 1;
   localparam int REQ_LINK_BIT   = REQ_TIME_LO + TIME_WIDTH;
   localparam int REQ_BITS       = REQ_LINK_BIT + 1;
   localparam int REQ_DATA_WIDTH = ((REQ_BITS + 7) / 8) * 8;

   // Response word layout, lowest bit first.
   localparam int RSP_CODE_LO    = 0;
   localparam int RSP_GEST_LO    = RSP_CODE_LO + CODE_WIDTH;
   localparam int RSP_SHAKE_BIT  = RSP_GEST_LO + GEST_WIDTH;
   localparam int RSP_TILTX_LO   = RSP_SHAKE_BIT + 1;
   localparam int RSP_TILTY_LO   = RSP_TILTX_LO + TILT_WIDTH;
   localparam int RSP_AX_LO      = RSP_TILTY_LO + TILT_WIDTH;
   localparam int RSP_AY_LO      = RSP_AX_LO + ACCEL_WIDTH;
   localparam int RSP_AZ_LO      = RSP_AY_LO + ACCEL_WIDTH;
   localparam int RSP_SEQ_LO     = RSP_AZ_LO + ACCEL_WIDTH;
   localparam int RSP_UP_LO      = RSP_SEQ_LO + COUNT_WIDTH;
   localparam int RSP_BITS       = RSP_UP_LO + UPTIME_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;

endpackage

@@ hw/rtl/motion_shake_gesture_telemetry.sv @@
// Top level of the shake gesture telemetry block: control, state and result word register.
//
// Each accepted request word carries one accelerometer sample in signed Q4.12 g plus a
// persona code, an external shake flag, the millisecond time and a link-up bit. A word
// with link_up low is consumed and changes nothing. A linked word runs through two
// bit-serial units in a row: the sum of squares takes one multiplier bit per cycle and
// the integer square root one root bit per cycle; the root is started when the sum is
// done and captured when the root is done. The division of the time by 1000 runs beside
// them. A baseline multiply step and an update step follow, then each result word is
// loaded into the output register once that register is free (a record also waits for
// the divider). Once the last result word is loaded, or after the update step if there
// is none, the block is back in idle and takes the next request word. A sample can
// produce a state event (kind 0, when the persona changes to a valid code below 7) and
// a telemetry record (kind 1, when the configured period has elapsed); the event always
// comes first and tlast marks the final word of the sample. Configuration registers may
// only be written while the block is idle.
module motion_shake_gesture_telemetry (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0 up: accel_x, accel_y, accel_z, persona, shake_in, time_ms,
   // link_up, zero fill.
   input  logic [mst_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // Result channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0 up: state_code, gesture, shake_flag, tilt_x, tilt_y, accel_x_out,
   // accel_y_out, accel_z_out, sequence_number, uptime_seconds, zero fill.
   output logic [mst_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // Field: kind.
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   // Configuration write port.
   input  logic                                 csr_we,
   input  logic [mst_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mst_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import mst_pkg::*;

   localparam logic signed [TILT_WIDTH-1:0] TILT_MAX = TILT_WIDTH'(ONE_G);

   state_type state_ff, state_in;

   // Configuration registers.
   logic [THR_WIDTH-1:0] thr_ff, thr_in;
   logic [WGT_WIDTH-1:0] wgt_ff, wgt_in;
   logic [PER_WIDTH-1:0] per_ff, per_in;

   // Persistent state.
   logic [BASE_WIDTH-1:0]    base_ff, base_in;
   logic [PERSONA_WIDTH-1:0] prev_ff, prev_in;
   logic [TIME_WIDTH-1:0]    last_pub_ff, last_pub_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                     event_ff, event_in;
   logic                     record_ff, record_in;

   // Sample held for the duration of the item.
   logic signed [ACCEL_WIDTH-1:0] ax_ff, ax_in;
   logic signed [ACCEL_WIDTH-1:0] ay_ff, ay_in;
   logic signed [ACCEL_WIDTH-1:0] az_ff, az_in;
   logic [PERSONA_WIDTH-1:0]      persona_ff, persona_in;
   logic                          ext_shake_ff, ext_shake_in;
   logic [TIME_WIDTH-1:0]         time_ff, time_in;
   logic [ACCEL_WIDTH-1:0]        mag_ff, mag_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic                          shake_flag_ff, shake_flag_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                      rsp_user_ff, rsp_user_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Serial unit handshakes.
   logic                    sq_start, sq_busy, sq_done;
   logic [SQ_WIDTH-1:0]     sq_sum;
   logic                    rt_start, rt_busy, rt_done;
   logic [ACCEL_WIDTH-1:0]  rt_root;
   logic                    div_start, div_busy;
   logic [UPTIME_WIDTH-1:0] uptime;

   // Control decodes.
   logic req_fire;
   logic req_link;
   logic out_free;
   logic load_event;
   logic load_record;

   // Datapath helpers.
   logic [BASE_WIDTH-1:0]        mag_ext;
   logic [BASE_WIDTH-1:0]        deviation;
   logic signed [DIFF_WIDTH-1:0] diff;
   logic signed [PROD_WIDTH-1:0] base_scaled;
   logic signed [PROD_WIDTH-1:0] blend;
   logic [TIME_WIDTH-1:0]        elapsed;
   logic                         persona_ok;
   logic [CODE_WIDTH-1:0]        record_code;
   gesture_type                  gesture;
   int                           ax_val, ay_val, az_val;
   logic [RSP_DATA_WIDTH-1:0]    event_word;
   logic [RSP_DATA_WIDTH-1:0]    record_word;

   function automatic logic signed [TILT_WIDTH-1:0] clamp_tilt(input int v);
      if (v > ONE_G) begin
         return TILT_WIDTH'(ONE_G);
      end else if (v < -ONE_G) begin
         return TILT_WIDTH'(-ONE_G);
      end
      return TILT_WIDTH'(v);
   endfunction

   assign req_fire = req_tvalid && req_tready;
   assign req_link = req_tdata[REQ_LINK_BIT];
   assign out_free = !rsp_valid_ff || rsp_tready;

   mst_sqsum u_sqsum (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .ax    (req_tdata[REQ_AX_LO +: ACCEL_WIDTH]),
      .ay    (req_tdata[REQ_AY_LO +: ACCEL_WIDTH]),
      .az    (req_tdata[REQ_AZ_LO +: ACCEL_WIDTH]),
      .busy  (sq_busy),
      .done  (sq_done),
      .sum   (sq_sum)
   );

   mst_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand (sq_sum),
      .busy     (rt_busy),
      .done     (rt_done),
      .root     (rt_root)
   );

   mst_div1000 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[REQ_TIME_LO +: TIME_WIDTH]),
      .busy     (div_busy),
      .quotient (uptime)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_link) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sq_done) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rt_done) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            priority if (event_in) begin
               state_in = ST_EVENT;
            end else if (record_in) begin
               state_in = ST_RECORD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EVENT: begin
            if (out_free) begin
               state_in = record_ff ? ST_RECORD : ST_IDLE;
            end
         end
         ST_RECORD: begin
            if (out_free && !div_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready  = 1'b0;
      sq_start    = 1'b0;
      div_start   = 1'b0;
      rt_start    = 1'b0;
      load_event  = 1'b0;
      load_record = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            sq_start   = req_tvalid && req_link;
            div_start  = req_tvalid && req_link;
         end
         ST_SQUARE: begin
            rt_start = sq_done;
         end
         ST_EVENT: begin
            load_event = out_free;
         end
         ST_RECORD: begin
            load_record = out_free && !div_busy;
         end
         default: begin
         end
      endcase
   end

   // Baseline and telemetry arithmetic.
   assign mag_ext     = BASE_WIDTH'(mag_ff);
   assign deviation   = (mag_ext > base_ff) ? (mag_ext - base_ff) : (base_ff - mag_ext);
   assign diff        = $signed(DIFF_WIDTH'(mag_ff)) - $signed(DIFF_WIDTH'(base_ff));
   // b*65536 + (mag - b)*w + 32768 equals b*(65536 - w) + mag*w + 32768.
   assign base_scaled = $signed(PROD_WIDTH'({base_ff, {WGT_WIDTH{1'b0}}}));
   assign blend       = base_scaled + prod_ff + $signed(PROD_WIDTH'(1) <<< (WGT_WIDTH - 1));
   assign elapsed     = time_ff - last_pub_ff;
   assign persona_ok  = persona_ff < PERSONA_WIDTH'(PERSONA_COUNT);
   assign record_code = persona_ok ? persona_ff[CODE_WIDTH-1:0] : PERSONA_IDLE;

   assign ax_val = int'(ax_ff);
   assign ay_val = int'(ay_ff);
   assign az_val = int'(az_ff);

   // Gesture class; a shake overrides every tilt based class.
   always_comb begin
      priority if (shake_flag_ff) begin
         gesture = GEST_DIZZY;
      end else if (az_val < FACEDOWN_LIMIT) begin
         gesture = GEST_FACEDOWN;
      end else if (ay_val > WAVE_LIMIT) begin
         gesture = GEST_WAVE;
      end else if (ax_val > LEAN_LIMIT) begin
         gesture = GEST_LEAN_RIGHT;
      end else if (ax_val < -LEAN_LIMIT) begin
         gesture = GEST_LEAN_LEFT;
      end else begin
         gesture = GEST_IDLE;
      end
   end

   always_comb begin
      event_word = '0;
      event_word[RSP_CODE_LO +: CODE_WIDTH] = persona_ff[CODE_WIDTH-1:0];
   end

   always_comb begin
      record_word = '0;
      record_word[RSP_CODE_LO +: CODE_WIDTH]    = record_code;
      record_word[RSP_GEST_LO +: GEST_WIDTH]    = gesture;
      record_word[RSP_SHAKE_BIT]                = shake_flag_ff;
      record_word[RSP_TILTX_LO +: TILT_WIDTH]   = clamp_tilt(ax_val);
      record_word[RSP_TILTY_LO +: TILT_WIDTH]   = clamp_tilt(ay_val);
      record_word[RSP_AX_LO +: ACCEL_WIDTH]     = ax_ff;
      record_word[RSP_AY_LO +: ACCEL_WIDTH]     = ay_ff;
      record_word[RSP_AZ_LO +: ACCEL_WIDTH]     = az_ff;
      record_word[RSP_SEQ_LO +: COUNT_WIDTH]    = count_ff;
      record_word[RSP_UP_LO +: UPTIME_WIDTH]    = uptime;
   end

   // Register next values.
   always_comb begin
      thr_in        = thr_ff;
      wgt_in        = wgt_ff;
      per_in        = per_ff;
      base_in       = base_ff;
      prev_in       = prev_ff;
      last_pub_in   = last_pub_ff;
      count_in      = count_ff;
      event_in      = event_ff;
      record_in     = record_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      az_in         = az_ff;
      persona_in    = persona_ff;
      ext_shake_in  = ext_shake_ff;
      time_in       = time_ff;
      mag_in        = mag_ff;
      prod_in       = prod_ff;
      shake_flag_in = shake_flag_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SHAKE_THRESHOLD:  thr_in = csr_wdata[THR_WIDTH-1:0];
            CSR_EMA_WEIGHT:       wgt_in = csr_wdata[WGT_WIDTH-1:0];
            CSR_TELEMETRY_PERIOD: per_in = csr_wdata[PER_WIDTH-1:0];
            default: begin
            end
         endcase
      end

      if (req_fire && req_link) begin
         ax_in        = req_tdata[REQ_AX_LO +: ACCEL_WIDTH];
         ay_in        = req_tdata[REQ_AY_LO +: ACCEL_WIDTH];
         az_in        = req_tdata[REQ_AZ_LO +: ACCEL_WIDTH];
         persona_in   = req_tdata[REQ_PERSONA_LO +: PERSONA_WIDTH];
         ext_shake_in = req_tdata[REQ_SHAKE_BIT];
         time_in      = req_tdata[REQ_TIME_LO +: TIME_WIDTH];
      end

      if (state_ff == ST_ROOT && rt_done) begin
         mag_in = rt_root;
      end

      // Shake is judged against the baseline from before this sample.
      if (state_ff == ST_MULT) begin
         prod_in       = diff * $signed({1'b0, wgt_ff});
         shake_flag_in = ext_shake_ff || (deviation > BASE_WIDTH'(thr_ff));
      end

      if (state_ff == ST_UPDATE) begin
         base_in   = blend[WGT_WIDTH +: BASE_WIDTH];
         event_in  = (persona_ff != prev_ff) && persona_ok;
         record_in = elapsed >= TIME_WIDTH'(per_ff);
         if (event_in) begin
            prev_in = persona_ff;
         end
         if (record_in) begin
            last_pub_in = time_ff;
            count_in    = count_ff + 1'b1;
         end
      end

      if (load_event) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = event_word;
         rsp_user_in  = KIND_STATE;
         rsp_last_in  = !record_ff;
      end else if (load_record) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = record_word;
         rsp_user_in  = KIND_TELEMETRY;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         wgt_ff       <= WGT_RESET;
         per_ff       <= PER_RESET;
         base_ff      <= BASE_WIDTH'(ONE_G);
         prev_ff      <= PERSONA_NONE;
         last_pub_ff  <= '0;
         count_ff     <= '0;
         event_ff     <= 1'b0;
         record_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         wgt_ff       <= wgt_in;
         per_ff       <= per_in;
         base_ff      <= base_in;
         prev_ff      <= prev_in;
         last_pub_ff  <= last_pub_in;
         count_ff     <= count_in;
         event_ff     <= event_in;
         record_ff    <= record_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      az_ff         <= az_in;
      persona_ff    <= persona_in;
      ext_shake_ff  <= ext_shake_in;
      time_ff       <= time_in;
      mag_ff        <= mag_in;
      prod_ff       <= prod_in;
      shake_flag_ff <= shake_flag_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // No serial unit may still be working once the block is ready for a new sample.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!sq_busy && !rt_busy && !div_busy))
      else $error("serial unit busy while idle");

   // The sequence count only moves in the update step of a sample.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_UPDATE) |=> $stable(count_ff))
      else $error("sequence count changed outside the update step");

   // A state event carries nothing beyond its code and always precedes or ends the sample.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff == KIND_STATE) |->
         (rsp_data_ff[RSP_DATA_WIDTH-1:CODE_WIDTH] == '0))
      else $error("state event with nonzero record fields");

   // Tilt in a record stays within one g.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff == KIND_TELEMETRY) |->
         ($signed(rsp_data_ff[RSP_TILTX_LO +: TILT_WIDTH]) <= TILT_MAX &&
          $signed(rsp_data_ff[RSP_TILTX_LO +: TILT_WIDTH]) >= -TILT_MAX &&
          $signed(rsp_data_ff[RSP_TILTY_LO +: TILT_WIDTH]) <= TILT_MAX &&
          $signed(rsp_data_ff[RSP_TILTY_LO +: TILT_WIDTH]) >= -TILT_MAX))
      else $error("tilt outside one g");

endmodule

@@ hw/rtl/mst_sqsum.sv @@
// Bit-serial sum of the squares of three signed axes, one multiplier bit per cycle.
module mst_sqsum (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic signed [mst_pkg::ACCEL_WIDTH-1:0]   ax,
   input  logic signed [mst_pkg::ACCEL_WIDTH-1:0]   ay,
   input  logic signed [mst_pkg::ACCEL_WIDTH-1:0]   az,
   output logic                                     busy,
   output logic                                     done,
   output logic        [mst_pkg::SQ_WIDTH-1:0]      sum
);
   import mst_pkg::*;

   logic [ACCEL_WIDTH-1:0]   mplr_ff [3];
   logic [ACCEL_WIDTH-1:0]   mplr_in [3];
   logic [SQ_WIDTH-1:0]      mcnd_ff [3];
   logic [SQ_WIDTH-1:0]      mcnd_in [3];
   logic [SQ_WIDTH-1:0]      acc_ff, acc_in;
   logic [SER_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [ACCEL_WIDTH-1:0]   mag [3];
   logic [SQ_WIDTH-1:0]      pp [3];

   // Magnitude of a two's complement value; the most negative one maps to 2^(w-1).
   function automatic logic [ACCEL_WIDTH-1:0] abs_val(input logic signed [ACCEL_WIDTH-1:0] v);
      return v[ACCEL_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   assign mag[0] = abs_val(ax);
   assign mag[1] = abs_val(ay);
   assign mag[2] = abs_val(az);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pp[i] = mplr_ff[i][0] ? mcnd_ff[i] : '0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      for (int i = 0; i < 3; i++) begin
         mplr_in[i] = mplr_ff[i];
         mcnd_in[i] = mcnd_ff[i];
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = SER_CNT_WIDTH'(ACCEL_WIDTH - 1);
         acc_in  = '0;
         for (int i = 0; i < 3; i++) begin
            mplr_in[i] = mag[i];
            mcnd_in[i] = SQ_WIDTH'(mag[i]);
         end
      end else if (busy_ff) begin
         acc_in = acc_ff + pp[0] + pp[1] + pp[2];
         for (int i = 0; i < 3; i++) begin
            mplr_in[i] = mplr_ff[i] >> 1;
            mcnd_in[i] = mcnd_ff[i] << 1;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      for (int i = 0; i < 3; i++) begin
         mplr_ff[i] <= mplr_in[i];
         mcnd_ff[i] <= mcnd_in[i];
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

@@ hw/rtl/mst_isqrt.sv @@
// Digit-serial integer square root: two radicand bits in, one root bit out per cycle.
module mst_isqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [mst_pkg::SQ_WIDTH-1:0]        radicand,
   output logic                                busy,
   output logic                                done,
   output logic [mst_pkg::ACCEL_WIDTH-1:0]     root
);
   import mst_pkg::*;

   logic [SQ_WIDTH-1:0]      rad_ff, rad_in;
   logic [ACCEL_WIDTH:0]     rem_ff, rem_in;
   logic [ACCEL_WIDTH-1:0]   root_ff, root_in;
   logic [SER_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [ACCEL_WIDTH+2:0]   rem_trial;
   logic [ACCEL_WIDTH+2:0]   sub_val;
   logic                     fits;

   // Partial remainder with the next radicand digit, against 4*root+1.
   assign rem_trial = {rem_ff, rad_ff[SQ_WIDTH-1 -: 2]};
   assign sub_val   = {1'b0, root_ff, 2'b01};
   assign fits      = rem_trial >= sub_val;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = SER_CNT_WIDTH'(ACCEL_WIDTH - 1);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = fits ? (ACCEL_WIDTH+1)'(rem_trial - sub_val) : (ACCEL_WIDTH+1)'(rem_trial);
         root_in = {root_ff[ACCEL_WIDTH-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hw/rtl/mst_div1000.sv @@
// Bit-serial restoring division of the millisecond time by 1000, one quotient bit per cycle.
module mst_div1000 (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [mst_pkg::TIME_WIDTH-1:0]       dividend,
   output logic                                 busy,
   output logic [mst_pkg::UPTIME_WIDTH-1:0]     quotient
);
   import mst_pkg::*;

   localparam logic [DIV_REM_WIDTH:0] DIVISOR = (DIV_REM_WIDTH+1)'(MS_PER_SECOND);

   // Dividend bits leave at the top while quotient bits enter at the bottom.
   logic [TIME_WIDTH-1:0]    dq_ff, dq_in;
   logic [DIV_REM_WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic [DIV_REM_WIDTH:0]   rem_trial;
   logic                     fits;

   assign rem_trial = {rem_ff, dq_ff[TIME_WIDTH-1]};
   assign fits      = rem_trial >= DIVISOR;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_WIDTH'(TIME_WIDTH - 1);
         dq_in   = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_REM_WIDTH'(rem_trial - DIVISOR) : DIV_REM_WIDTH'(rem_trial);
         dq_in  = {dq_ff[TIME_WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = dq_ff[UPTIME_WIDTH-1:0];

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the shake gesture telemetry block.
module testbench;
   import mst_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 9;
   // A linked word keeps the block busy even when it yields nothing, so every drain
   // also waits DRAIN_CYCLES after the last awaited word has arrived.
   localparam int DRAIN_CYCLES   = 2 * ACCEL_WIDTH + 16;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_WORDS    = 194;
   localparam int IDLE_PERCENT   = 25;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;

   // One accelerometer sample as it travels in a request word.
   typedef struct {
      logic signed [ACCEL_WIDTH-1:0] ax;
      logic signed [ACCEL_WIDTH-1:0] ay;
      logic signed [ACCEL_WIDTH-1:0] az;
      logic [PERSONA_WIDTH-1:0]      persona;
      logic                          shake;
      logic [TIME_WIDTH-1:0]         ms;
      logic                          link;
   } accel_sample_type;

   // One result word, every field kept as the raw bits it has on the bus.
   typedef struct {
      kind_type                   kind;
      logic [CODE_WIDTH-1:0]      code;
      gesture_type                gesture;
      logic                       shake;
      logic [TILT_WIDTH-1:0]      tilt_x;
      logic [TILT_WIDTH-1:0]      tilt_y;
      logic [ACCEL_WIDTH-1:0]     ax;
      logic [ACCEL_WIDTH-1:0]     ay;
      logic [ACCEL_WIDTH-1:0]     az;
      logic [COUNT_WIDTH-1:0]     seq_num;
      logic [UPTIME_WIDTH-1:0]    uptime;
      logic                       last;
   } telemetry_report_type;

   // Block ports. Every input holds a known value from time zero on.
   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_DATA_WIDTH-1:0]    req_tdata  = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]    rsp_tdata;
   logic                         rsp_tuser;
   logic                         rsp_tlast;
   logic                         csr_we     = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]    csr_wdata  = '0;

   // Shadow copy of the block's registers and internal state, kept in step with
   // every accepted request word and every register write.
   longint unsigned              shake_thr     = THR_RESET;
   longint unsigned              ema_w         = WGT_RESET;
   longint unsigned              period_ms     = PER_RESET;
   longint unsigned              mag_baseline  = ONE_G;
   logic [PERSONA_WIDTH-1:0]     prev_persona  = PERSONA_NONE;
   logic [TIME_WIDTH-1:0]        last_publish  = '0;
   logic [COUNT_WIDTH-1:0]       record_count  = '0;

   // Result words that the shadow model says are still to come, oldest first.
   telemetry_report_type         awaited_reports[$];
   telemetry_report_type         checked_report;
   int                           mismatch_count = 0;
   // When cleared, neither the sender nor the receiver inserts any idle cycles.
   bit                           idling_on      = 1'b1;

   motion_shake_gesture_telemetry i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // The receiver stalls in about a quarter of the cycles while idling is on.
   always @(posedge clock) begin
      rsp_tready <= !(idling_on && ($urandom_range(99) < IDLE_PERCENT));
   end

   // Clamps one axis to plus or minus one g and returns the 14-bit bus value.
   function automatic logic [TILT_WIDTH-1:0] clamp_one_g(logic signed [ACCEL_WIDTH-1:0] v);
      int t;
      t = v;
      if (t > ONE_G) t = ONE_G;
      else if (t < -ONE_G) t = -ONE_G;
      return t[TILT_WIDTH-1:0];
   endfunction

   function automatic accel_sample_type make_sample(int ax, int ay, int az, int persona,
                                                    bit shake, logic [TIME_WIDTH-1:0] ms,
                                                    bit link);
      accel_sample_type s;
      s.ax      = ACCEL_WIDTH'(ax);
      s.ay      = ACCEL_WIDTH'(ay);
      s.az      = ACCEL_WIDTH'(az);
      s.persona = PERSONA_WIDTH'(persona);
      s.shake   = shake;
      s.ms      = ms;
      s.link    = link;
      return s;
   endfunction

   // Works out the result words that one accepted sample causes and advances the
   // shadow state exactly as the block does.
   task automatic forecast_reports(accel_sample_type s);
      longint signed     ax;
      longint signed     ay;
      longint signed     az;
      longint unsigned   sq;
      longint unsigned   rem;
      longint unsigned   root;
      longint unsigned   probe;
      longint unsigned   dev;
      logic              shaken;
      logic [TIME_WIDTH-1:0] elapsed;
      bit                record_due;
      telemetry_report_type r;

      if (!s.link) return;

      ax = s.ax;
      ay = s.ay;
      az = s.az;
      sq = ax * ax + ay * ay + az * az;

      // Floor of the square root, two bits of the radicand per step.
      rem   = sq;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end

      dev    = (root > mag_baseline) ? root - mag_baseline : mag_baseline - root;
      shaken = s.shake || (dev > shake_thr);
      mag_baseline = (mag_baseline * (65536 - ema_w) + root * ema_w + 32768) >> 16;

      elapsed    = s.ms - last_publish;
      record_due = (elapsed >= period_ms);

      // A change to a valid persona comes first; beyond kind, code and last, every field is zero.
      if (s.persona != prev_persona && s.persona < PERSONA_COUNT) begin
         prev_persona = s.persona;
         r.kind    = KIND_STATE;
         r.code    = s.persona[CODE_WIDTH-1:0];
         r.gesture = GEST_IDLE;
         r.shake   = 1'b0;
         r.tilt_x  = '0;
         r.tilt_y  = '0;
         r.ax      = '0;
         r.ay      = '0;
         r.az      = '0;
         r.seq_num = '0;
         r.uptime  = '0;
         r.last    = !record_due;
         awaited_reports.push_back(r);
      end

      if (record_due) begin
         last_publish = s.ms;
         record_count = record_count + 1;
         r.kind = KIND_TELEMETRY;
         r.code = (s.persona < PERSONA_COUNT) ? s.persona[CODE_WIDTH-1:0] : PERSONA_IDLE;
         // Shake wins over every posture test, which then apply in fixed order.
         if (shaken) r.gesture = GEST_DIZZY;
         else if (s.az < FACEDOWN_LIMIT) r.gesture = GEST_FACEDOWN;
         else if (s.ay > WAVE_LIMIT) r.gesture = GEST_WAVE;
         else if (s.ax > LEAN_LIMIT) r.gesture = GEST_LEAN_RIGHT;
         else if (s.ax < -LEAN_LIMIT) r.gesture = GEST_LEAN_LEFT;
         else r.gesture = GEST_IDLE;
         r.shake   = shaken;
         r.tilt_x  = clamp_one_g(s.ax);
         r.tilt_y  = clamp_one_g(s.ay);
         r.ax      = s.ax;
         r.ay      = s.ay;
         r.az      = s.az;
         r.seq_num = record_count;
         r.uptime  = UPTIME_WIDTH'(s.ms / MS_PER_SECOND);
         r.last    = 1'b1;
         awaited_reports.push_back(r);
      end
   endtask

   // Offers one request word and returns at the clock edge that takes it. The
   // valid stays high afterward, so the caller either sends the next word at
   // once or drains; both of those change the valid in that same step only once.
   task automatic send_sample(accel_sample_type s);
      logic [REQ_DATA_WIDTH-1:0] word;

      word = '0;
      word[REQ_AX_LO +: ACCEL_WIDTH]        = s.ax;
      word[REQ_AY_LO +: ACCEL_WIDTH]        = s.ay;
      word[REQ_AZ_LO +: ACCEL_WIDTH]        = s.az;
      word[REQ_PERSONA_LO +: PERSONA_WIDTH] = s.persona;
      word[REQ_SHAKE_BIT]                   = s.shake;
      word[REQ_TIME_LO +: TIME_WIDTH]       = s.ms;
      word[REQ_LINK_BIT]                    = s.link;

      // Gaps of up to a full processing time, so they land on every phase.
      if (idling_on && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(45, 1)) @(posedge clock);
      end
      req_tdata  <= word;
      req_tvalid <= 1'b1;

      // Everything settles by the falling edge, so the handshake is judged there.
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      forecast_reports(s);
   endtask

   // Lets every awaited word arrive, then waits out a word that yields nothing.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SHAKE_THRESHOLD:  shake_thr = value[THR_WIDTH-1:0];
         CSR_EMA_WEIGHT:       ema_w     = value[WGT_WIDTH-1:0];
         CSR_TELEMETRY_PERIOD: period_ms = value[PER_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Every result word taken by the receiver is matched with the oldest awaited one.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_reports.size() == 0) begin
            $error("result word arrived with none awaited");
            mismatch_count++;
         end else begin
            checked_report = awaited_reports.pop_front();
            compare_field("kind", checked_report.kind, rsp_tuser);
            compare_field("state_code", checked_report.code,
                          rsp_tdata[RSP_CODE_LO +: CODE_WIDTH]);
            compare_field("gesture", checked_report.gesture,
                          rsp_tdata[RSP_GEST_LO +: GEST_WIDTH]);
            compare_field("shake_flag", checked_report.shake, rsp_tdata[RSP_SHAKE_BIT]);
            compare_field("tilt_x", checked_report.tilt_x,
                          rsp_tdata[RSP_TILTX_LO +: TILT_WIDTH]);
            compare_field("tilt_y", checked_report.tilt_y,
                          rsp_tdata[RSP_TILTY_LO +: TILT_WIDTH]);
            compare_field("accel_x_out", checked_report.ax,
                          rsp_tdata[RSP_AX_LO +: ACCEL_WIDTH]);
            compare_field("accel_y_out", checked_report.ay,
                          rsp_tdata[RSP_AY_LO +: ACCEL_WIDTH]);
            compare_field("accel_z_out", checked_report.az,
                          rsp_tdata[RSP_AZ_LO +: ACCEL_WIDTH]);
            compare_field("sequence_number", checked_report.seq_num,
                          rsp_tdata[RSP_SEQ_LO +: COUNT_WIDTH]);
            compare_field("uptime_seconds", checked_report.uptime,
                          rsp_tdata[RSP_UP_LO +: UPTIME_WIDTH]);
            compare_field("last", checked_report.last, rsp_tlast);
         end
      end
   end

   // Reset register values: every gesture, the axis extremes, tilt clamping and a
   // sample that falls inside the telemetry period.
   task automatic test_reset_defaults();
      send_sample(make_sample(0, 0, ONE_G, 1, 1'b0, 100, 1'b1));
      send_sample(make_sample(0, 0, -ONE_G, 1, 1'b0, 200, 1'b1));
      send_sample(make_sample(0, 3000, 2900, 1, 1'b0, 300, 1'b1));
      send_sample(make_sample(3000, 0, 2800, 1, 1'b0, 400, 1'b1));
      send_sample(make_sample(-3000, 0, 2800, 1, 1'b0, 500, 1'b1));
      send_sample(make_sample(0, 0, ONE_G, 1, 1'b1, 600, 1'b1));
      send_sample(make_sample(16000, 0, 0, 1, 1'b0, 700, 1'b1));
      send_sample(make_sample(-32768, 32767, -32768, 6, 1'b0, 800, 1'b1));
      send_sample(make_sample(0, 0, ONE_G, 6, 1'b0, 850, 1'b1));
      wait_idle();
   endtask

   // Words with the link down change nothing; invalid and repeated personas give
   // no state event, and a record then reports the idle code.
   task automatic test_link_and_personas();
      send_sample(make_sample(20000, -20000, 5, 4, 1'b1, 5000, 1'b0));
      send_sample(make_sample(100, -100, ONE_G, 9, 1'b0, 1000, 1'b1));
      send_sample(make_sample(-100, 100, ONE_G, 6, 1'b0, 1100, 1'b1));
      send_sample(make_sample(0, 0, ONE_G, 0, 1'b0, 1150, 1'b1));
      send_sample(make_sample(50, 50, ONE_G, 15, 1'b0, 1300, 1'b1));
      send_sample(make_sample(-1, -1, -1, 2, 1'b1, 32'hFFFF_FFFF, 1'b0));
      wait_idle();
   endtask

   // A zero period records every linked word; the longest period is checked at its
   // boundary across the wrap of the millisecond time.
   task automatic test_time_wrap_and_period();
      write_csr(CSR_TELEMETRY_PERIOD, 16'd0);
      send_sample(make_sample(1, 2, 3, 3, 1'b0, 32'hFFFF_FFF0, 1'b1));
      send_sample(make_sample(1, 2, 3, 3, 1'b0, 32'hFFFF_FFF0, 1'b1));
      wait_idle();
      write_csr(CSR_TELEMETRY_PERIOD, 16'hFFFF);
      send_sample(make_sample(0, 0, ONE_G, 3, 1'b0, 32'h0000_0010, 1'b1));
      send_sample(make_sample(0, 0, ONE_G, 3, 1'b0, 32'h0000_FFEF, 1'b1));
      wait_idle();
   endtask

   // Threshold and weight at both ends; the top bit of the threshold write falls
   // away, and a write to the unused index leaves every register alone.
   task automatic test_register_extremes();
      write_csr(CSR_SHAKE_THRESHOLD, 16'hFFFF);
      write_csr(CSR_EMA_WEIGHT, 16'hFFFF);
      write_csr(CSR_TELEMETRY_PERIOD, 16'd0);
      write_csr(CSR_UNUSED_INDEX, 16'h0000);
      send_sample(make_sample(32767, 32767, 32767, 5, 1'b0, 32'h0001_0000, 1'b1));
      send_sample(make_sample(0, 0, 0, 5, 1'b0, 32'h0001_0001, 1'b1));
      wait_idle();
      write_csr(CSR_SHAKE_THRESHOLD, 16'd0);
      write_csr(CSR_EMA_WEIGHT, 16'd0);
      send_sample(make_sample(0, 0, ONE_G, 5, 1'b0, 32'h0001_0002, 1'b1));
      send_sample(make_sample(0, 0, 0, 5, 1'b0, 32'h0001_0003, 1'b1));
      wait_idle();
   endtask

   // Random phases, each with its own register setting. Most samples look like a
   // device at rest near one g, the rest tilt, shake or use the full range.
   task automatic test_random_stream();
      int                        phase;
      int                        n;
      int                        pick;
      int                        ax;
      int                        ay;
      int                        az;
      int                        grav;
      int                        persona;
      int                        cur_persona;
      logic [TIME_WIDTH-1:0]     clock_ms;
      logic [CSR_DATA_WIDTH-1:0] thr_word;
      logic [CSR_DATA_WIDTH-1:0] wgt_word;
      logic [CSR_DATA_WIDTH-1:0] per_word;

      cur_persona = 1;
      clock_ms    = 32'h0002_0000;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         // One whole phase runs without any idle cycles on either side.
         idling_on = (phase != 3);
         case (phase)
            0: begin
               thr_word = 16'd0;
               wgt_word = 16'd0;
               per_word = 16'd0;
            end
            1: begin
               thr_word = 16'h7FFF;
               wgt_word = 16'hFFFF;
               per_word = 16'hFFFF;
            end
            2: begin
               thr_word = THR_RESET;
               wgt_word = WGT_RESET;
               per_word = PER_RESET;
            end
            default: begin
               thr_word = CSR_DATA_WIDTH'(($urandom_range(3) == 0) ?
                                          $urandom_range(32767) :
                                          $urandom_range(5000, 300));
               wgt_word = CSR_DATA_WIDTH'(($urandom_range(3) == 0) ?
                                          $urandom_range(65535) :
                                          $urandom_range(20000, 1000));
               per_word = CSR_DATA_WIDTH'($urandom_range(150));
            end
         endcase
         // The threshold register is 15 bits wide; its top data bit is don't-care.
         thr_word[CSR_DATA_WIDTH-1] = 1'($urandom_range(1));
         write_csr(CSR_SHAKE_THRESHOLD, thr_word);
         write_csr(CSR_EMA_WEIGHT, wgt_word);
         write_csr(CSR_TELEMETRY_PERIOD, per_word);

         for (n = 0; n < PHASE_WORDS; n++) begin
            // Hold the sender once until everything awaited has come back.
            if (phase == 2 && n == PHASE_WORDS / 2) wait_idle();

            pick = $urandom_range(99);
            if (pick < 60) begin
               ax   = int'($urandom_range(800)) - 400;
               ay   = int'($urandom_range(800)) - 400;
               az   = int'($urandom_range(800)) - 400;
               grav = ($urandom_range(1) != 0) ? ONE_G : -ONE_G;
               case ($urandom_range(2))
                  0: ax = ax + grav;
                  1: ay = ay + grav;
                  default: az = az + grav;
               endcase
            end else if (pick < 80) begin
               ax = int'($urandom_range(10000)) - 5000;
               ay = int'($urandom_range(10000)) - 5000;
               az = int'($urandom_range(10000)) - 5000;
            end else if (pick < 90) begin
               ax = int'($urandom_range(40000)) - 20000;
               ay = int'($urandom_range(40000)) - 20000;
               az = int'($urandom_range(40000)) - 20000;
            end else begin
               ax = $urandom();
               ay = $urandom();
               az = $urandom();
            end

            // Personas mostly hold, sometimes move, and now and then are invalid.
            pick = $urandom_range(99);
            if (pick < 12) cur_persona = $urandom_range(PERSONA_COUNT - 1);
            persona = (pick >= 95) ? $urandom_range(15) : cur_persona;

            pick = $urandom_range(99);
            if (pick < 85) clock_ms = clock_ms + $urandom_range(80);
            else if (pick < 95) clock_ms = clock_ms + $urandom_range(70000);
            else clock_ms = $urandom();

            send_sample(make_sample(ax, ay, az, persona, $urandom_range(99) < 10,
                                    clock_ms, $urandom_range(99) < 92));
         end
         wait_idle();
      end
      idling_on = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_link_and_personas();
      test_time_wrap_and_period();
      test_register_extremes();
      test_random_stream();
      // Every test ends drained, so nothing is awaited here any more.
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // A hung handshake or a result that never comes ends the run here.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Mismatches found");
      $finish;
   end

endmodule
